// ===== src/ami_pkg.sv =====
// ---------------------------------------------------------------------------
// ami_pkg
// Widths and the divider stage type shared by the affine matrix inverse pipeline.
// ---------------------------------------------------------------------------
package ami_pkg;

   localparam int COEF_WIDTH = 32;
   localparam int FRAC_BITS  = 16;

   localparam int PROD_W  = 2 * COEF_WIDTH;
   localparam int SUM_W   = 2 * COEF_WIDTH + 1;
   localparam int DEN_W   = 2 * COEF_WIDTH;
   localparam int NUM_W   = (2 * COEF_WIDTH + FRAC_BITS > COEF_WIDTH + 2 * FRAC_BITS) ?
                            (2 * COEF_WIDTH + FRAC_BITS) : (COEF_WIDTH + 2 * FRAC_BITS);
   localparam int NUMS_W  = NUM_W + 1;
   localparam int QUO_W   = COEF_WIDTH + 1;
   localparam int EXT_W   = (NUM_W > DEN_W + QUO_W) ? NUM_W : (DEN_W + QUO_W);
   localparam int N_TERMS = 6;

   typedef struct packed {
      logic                                vld;
      logic                                inv;
      logic [DEN_W-1:0]                    den;
      logic [N_TERMS-1:0]                  neg;
      logic [N_TERMS-1:0]                  ovf;
      logic [N_TERMS-1:0][NUM_W-1:0]       rem;
      logic [N_TERMS-1:0][QUO_W-1:0]       quo;
   } div_stage_type;

endpackage

// ===== src/affine_matrix_inverse_top.sv =====
// ---------------------------------------------------------------------------
// affine_matrix_inverse_top
// Inverts a 2x3 affine matrix of signed Q16.16 coefficients with saturation.
// ---------------------------------------------------------------------------
// One matrix is taken per cycle while the result is not stalled; its inverse
// passes through one stage of products, one of sums, one of magnitudes, one
// overflow check, one restoring division stage per quotient bit (COEF_WIDTH +
// 1 of them, six dividers side by side) and the output register. A stalled
// result freezes the whole pipeline; nothing is dropped. Singular matrices
// give invertible low and all-zero terms.
module affine_matrix_inverse_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic signed [ami_pkg::COEF_WIDTH-1:0] req_coef_a,
   input  logic signed [ami_pkg::COEF_WIDTH-1:0] req_coef_b,
   input  logic signed [ami_pkg::COEF_WIDTH-1:0] req_coef_c,
   input  logic signed [ami_pkg::COEF_WIDTH-1:0] req_coef_d,
   input  logic signed [ami_pkg::COEF_WIDTH-1:0] req_coef_e,
   input  logic signed [ami_pkg::COEF_WIDTH-1:0] req_coef_f,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic signed [ami_pkg::COEF_WIDTH-1:0] rsp_inv_a,
   output logic signed [ami_pkg::COEF_WIDTH-1:0] rsp_inv_b,
   output logic signed [ami_pkg::COEF_WIDTH-1:0] rsp_inv_c,
   output logic signed [ami_pkg::COEF_WIDTH-1:0] rsp_inv_d,
   output logic signed [ami_pkg::COEF_WIDTH-1:0] rsp_inv_e,
   output logic signed [ami_pkg::COEF_WIDTH-1:0] rsp_inv_f,
   output logic        rsp_invertible,
   output logic        rsp_saturated
);

   localparam int CW  = ami_pkg::COEF_WIDTH;
   localparam int FB  = ami_pkg::FRAC_BITS;
   localparam int PW  = ami_pkg::PROD_W;
   localparam int SW  = ami_pkg::SUM_W;
   localparam int DW  = ami_pkg::DEN_W;
   localparam int NW  = ami_pkg::NUM_W;
   localparam int NSW = ami_pkg::NUMS_W;
   localparam int QW  = ami_pkg::QUO_W;
   localparam int EW  = ami_pkg::EXT_W;
   localparam int NT  = ami_pkg::N_TERMS;

   logic advance;

   // stage 1: products
   logic s1_vld_ff;
   logic signed [PW-1:0] s1_ae_ff, s1_bd_ff, s1_bf_ff, s1_ec_ff, s1_dc_ff, s1_af_ff;
   logic signed [CW-1:0] s1_a_ff, s1_b_ff, s1_d_ff, s1_e_ff;

   // stage 2: determinant and translation numerators
   logic s2_vld_ff;
   logic signed [SW-1:0] s2_det_ff, s2_numc_ff, s2_numf_ff;
   logic signed [CW-1:0] s2_a_ff, s2_b_ff, s2_d_ff, s2_e_ff;

   // stage 3: magnitudes and signs
   logic s3_vld_ff, s3_inv_ff;
   logic [DW-1:0]          s3_den_ff;
   logic [NT-1:0]          s3_neg_ff;
   logic [NT-1:0][NW-1:0]  s3_mag_ff;

   logic signed [NSW-1:0]  num_s [NT];
   logic [NT-1:0][NW-1:0]  mag_in;
   logic [NT-1:0]          neg_in;
   logic                   det_neg;
   logic [DW-1:0]          den_in;

   ami_pkg::div_stage_type div_ff [QW+1];
   ami_pkg::div_stage_type div_in [QW+1];

   logic                  out_vld_ff, out_inv_ff, out_sat_ff;
   logic [NT-1:0][CW-1:0] out_val_ff;
   logic [NT-1:0][CW-1:0] val_in;
   logic [NT-1:0]         sat_in;

   assign advance   = !out_vld_ff || !rsp_stall;
   assign req_stall = !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (advance) begin
         s1_vld_ff <= req_valid;
      end
      if (advance) begin
         s1_ae_ff <= PW'(req_coef_a) * PW'(req_coef_e);
         s1_bd_ff <= PW'(req_coef_b) * PW'(req_coef_d);
         s1_bf_ff <= PW'(req_coef_b) * PW'(req_coef_f);
         s1_ec_ff <= PW'(req_coef_e) * PW'(req_coef_c);
         s1_dc_ff <= PW'(req_coef_d) * PW'(req_coef_c);
         s1_af_ff <= PW'(req_coef_a) * PW'(req_coef_f);
         s1_a_ff  <= req_coef_a;
         s1_b_ff  <= req_coef_b;
         s1_d_ff  <= req_coef_d;
         s1_e_ff  <= req_coef_e;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (advance) begin
         s2_vld_ff <= s1_vld_ff;
      end
      if (advance) begin
         s2_det_ff  <= SW'(s1_ae_ff) - SW'(s1_bd_ff);
         s2_numc_ff <= SW'(s1_bf_ff) - SW'(s1_ec_ff);
         s2_numf_ff <= SW'(s1_dc_ff) - SW'(s1_af_ff);
         s2_a_ff    <= s1_a_ff;
         s2_b_ff    <= s1_b_ff;
         s2_d_ff    <= s1_d_ff;
         s2_e_ff    <= s1_e_ff;
      end
   end

   // scaled numerators in the order of the result terms
   always_comb begin
      num_s[0] = NSW'(s2_e_ff) <<< (2 * FB);
      num_s[1] = -(NSW'(s2_b_ff) <<< (2 * FB));
      num_s[2] = NSW'(s2_numc_ff) <<< FB;
      num_s[3] = -(NSW'(s2_d_ff) <<< (2 * FB));
      num_s[4] = NSW'(s2_a_ff) <<< (2 * FB);
      num_s[5] = NSW'(s2_numf_ff) <<< FB;
      det_neg  = s2_det_ff[SW-1];
      den_in   = det_neg ? DW'(-s2_det_ff) : DW'(s2_det_ff);
      for (int k = 0; k < NT; k++) begin
         mag_in[k] = num_s[k][NSW-1] ? NW'(-num_s[k]) : NW'(num_s[k]);
         neg_in[k] = num_s[k][NSW-1] ^ det_neg;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else if (advance) begin
         s3_vld_ff <= s2_vld_ff;
      end
      if (advance) begin
         s3_inv_ff <= (s2_det_ff != '0);
         s3_den_ff <= den_in;
         s3_neg_ff <= neg_in;
         s3_mag_ff <= mag_in;
      end
   end

   // overflow check, then one restoring step per quotient bit
   always_comb begin
      div_in[0]     = div_ff[0];
      div_in[0].vld = s3_vld_ff;
      div_in[0].inv = s3_inv_ff;
      div_in[0].den = s3_den_ff;
      div_in[0].neg = s3_neg_ff;
      div_in[0].rem = s3_mag_ff;
      div_in[0].quo = '0;
      for (int k = 0; k < NT; k++) begin
         div_in[0].ovf[k] = EW'(s3_mag_ff[k]) >= (EW'(s3_den_ff) << QW);
      end
      for (int s = 0; s < QW; s++) begin
         div_in[s+1] = div_ff[s];
         for (int k = 0; k < NT; k++) begin
            if (EW'(div_ff[s].rem[k]) >= (EW'(div_ff[s].den) << (QW - 1 - s))) begin
               div_in[s+1].rem[k] = NW'(EW'(div_ff[s].rem[k]) -
                                        (EW'(div_ff[s].den) << (QW - 1 - s)));
               div_in[s+1].quo[k][QW-1-s] = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s <= QW; s++) begin
         if (reset) begin
            div_ff[s].vld <= 1'b0;
         end else if (advance) begin
            div_ff[s].vld <= div_in[s].vld;
         end
         if (advance) begin
            div_ff[s].inv <= div_in[s].inv;
            div_ff[s].den <= div_in[s].den;
            div_ff[s].neg <= div_in[s].neg;
            div_ff[s].ovf <= div_in[s].ovf;
            div_ff[s].rem <= div_in[s].rem;
            div_ff[s].quo <= div_in[s].quo;
         end
      end
   end

   // sign, clamp and singular handling
   always_comb begin
      for (int k = 0; k < NT; k++) begin
         if (div_ff[QW].neg[k]) begin
            sat_in[k] = div_ff[QW].ovf[k] ||
                        (div_ff[QW].quo[k] > (QW'(1) << (CW - 1)));
            val_in[k] = sat_in[k] ? (CW'(1) << (CW - 1)) : CW'(-div_ff[QW].quo[k]);
         end else begin
            sat_in[k] = div_ff[QW].ovf[k] ||
                        (div_ff[QW].quo[k] > ((QW'(1) << (CW - 1)) - QW'(1)));
            val_in[k] = sat_in[k] ? ((CW'(1) << (CW - 1)) - CW'(1))
                                  : CW'(div_ff[QW].quo[k]);
         end
         if (!div_ff[QW].inv) begin
            sat_in[k] = 1'b0;
            val_in[k] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         out_vld_ff <= div_ff[QW].vld;
      end
      if (advance) begin
         out_inv_ff <= div_ff[QW].inv;
         out_sat_ff <= |sat_in;
         out_val_ff <= val_in;
      end
   end

   assign rsp_valid      = out_vld_ff;
   assign rsp_inv_a      = out_val_ff[0];
   assign rsp_inv_b      = out_val_ff[1];
   assign rsp_inv_c      = out_val_ff[2];
   assign rsp_inv_d      = out_val_ff[3];
   assign rsp_inv_e      = out_val_ff[4];
   assign rsp_inv_f      = out_val_ff[5];
   assign rsp_invertible = out_inv_ff;
   assign rsp_saturated  = out_sat_ff;

endmodule

// ===== sim/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench
// Drives random and corner-case affine matrices into the inverse pipeline and
// checks every inverse against an exact wide-arithmetic prediction.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

   localparam int CW        = ami_pkg::COEF_WIDTH;
   localparam int FB        = ami_pkg::FRAC_BITS;
   localparam int LATENCY   = CW + 6;
   localparam int N_RANDOM  = 1050;
   localparam int MAX_CYCLE = 400000;

   // kinds of generated matrix
   localparam int KIND_SINGULAR = 0;
   localparam int KIND_DIAGONAL = 1;

   typedef logic signed [CW-1:0] coef_type;

   typedef struct {
      coef_type a, b, c, d, e, f;
   } matrix_type;

   typedef struct {
      coef_type a, b, c, d, e, f;
      logic  invertible;
      logic  saturated;
   } inverse_type;

   logic  clock;
   logic  reset;
   logic  req_valid;
   logic  req_stall;
   coef_type req_coef_a, req_coef_b, req_coef_c, req_coef_d, req_coef_e, req_coef_f;
   logic  rsp_valid;
   logic  rsp_stall;
   coef_type rsp_inv_a, rsp_inv_b, rsp_inv_c, rsp_inv_d, rsp_inv_e, rsp_inv_f;
   logic  rsp_invertible;
   logic  rsp_saturated;

   matrix_type  pending_q[$];
   inverse_type inverse_q[$];
   int       error_count;
   int       cycle_count;
   bit       stim_done;
   bit       drain_hold;
   int       hold_cycles;
   int       burst_left;
   int       gap_left;

   affine_matrix_inverse_top dut (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // exact quotient, truncated toward zero, clamped to the coefficient range
   function automatic coef_type quotient_sat(input logic signed [191:0] num,
                                             input logic signed [191:0] den,
                                             inout logic sat);
      logic signed [191:0] q;
      logic signed [191:0] hi_lim;
      logic signed [191:0] lo_lim;
      q      = num / den;
      hi_lim = (192'sd1 <<< (CW - 1)) - 1;
      lo_lim = -(192'sd1 <<< (CW - 1));
      if (q > hi_lim) begin
         sat = 1'b1;
         q   = hi_lim;
      end else if (q < lo_lim) begin
         sat = 1'b1;
         q   = lo_lim;
      end
      return q[CW-1:0];
   endfunction

   function automatic inverse_type invert_matrix(input matrix_type m);
      inverse_type r;
      logic signed [191:0] a, b, c, d, e, f, det, numc, numf;
      logic sat;
      a = m.a; b = m.b; c = m.c; d = m.d; e = m.e; f = m.f;
      det = a * e - b * d;
      sat = 1'b0;
      r = '{default: '0};
      if (det != 0) begin
         numc = b * f - e * c;
         numf = d * c - a * f;
         r.a = quotient_sat(e <<< (2 * FB), det, sat);
         r.b = quotient_sat(-(b <<< (2 * FB)), det, sat);
         r.c = quotient_sat(numc <<< FB, det, sat);
         r.d = quotient_sat(-(d <<< (2 * FB)), det, sat);
         r.e = quotient_sat(a <<< (2 * FB), det, sat);
         r.f = quotient_sat(numf <<< FB, det, sat);
         r.invertible = 1'b1;
         r.saturated  = sat;
      end
      return r;
   endfunction

   task automatic add_matrix(input matrix_type m);
      pending_q = {pending_q, m};
   endtask

   task automatic add_prediction(input matrix_type m);
      inverse_q = {inverse_q, invert_matrix(m)};
   endtask

   task automatic report_mismatch(input string what, input logic [CW-1:0] got,
                                  input logic [CW-1:0] want);
      $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycle_count);
      error_count++;
   endtask

   function automatic coef_type pick_coef();
      case ($urandom_range(0, 9))
         0: return coef_type'($urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000);
         1: return coef_type'(0);
         2: return coef_type'($urandom_range(0, 1) ? 32'h00010000 : 32'hffff0000);
         3: return coef_type'($signed($urandom_range(0, 7)) - 3);
         4, 5: return coef_type'($signed($urandom_range(0, 32'h3ffff)) - 32'sh20000);
         default: return coef_type'($urandom);
      endcase
   endfunction

   function automatic matrix_type make_matrix(input int kind);
      matrix_type m;
      m = '{pick_coef(), pick_coef(), pick_coef(), pick_coef(), pick_coef(), pick_coef()};
      if (kind == KIND_SINGULAR) begin
         // singular: linear part of the second row a scaled copy of the first
         m.d = m.a * 2;
         m.e = m.b * 2;
      end else if (kind == KIND_DIAGONAL) begin
         m.b = 0;
         m.d = 0;
      end
      return m;
   endfunction

   // stimulus
   initial begin
      matrix_type m;
      error_count = 0;
      stim_done   = 1'b0;
      drain_hold  = 1'b0;
      m = '{32'h00010000, 0, 0, 0, 32'h00010000, 0};                    add_matrix(m);
      m = '{32'h00020000, 0, 32'h00050000, 0, 32'h00040000, 32'hfffd0000}; add_matrix(m);
      m = '{0, 0, 0, 0, 0, 0};                                          add_matrix(m);
      m = '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
            32'h7fffffff};                                              add_matrix(m);
      m = '{32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
            32'h80000000};                                              add_matrix(m);
      m = '{32'h80000000, 0, 32'h7fffffff, 0, 32'h80000000, 32'h80000000}; add_matrix(m);
      m = '{32'h7fffffff, 32'h80000000, 32'h12345678, 32'h7fffffff, 32'h80000000,
            32'h87654321};                                              add_matrix(m);
      m = '{1, 0, 32'h7fffffff, 0, 1, 32'h80000000};                    add_matrix(m);
      m = '{32'hffffffff, 0, 0, 0, 1, 0};                               add_matrix(m);
      m = '{0, 32'h00010000, 32'h00030000, 32'hffff0000, 0, 32'h00070000}; add_matrix(m);
      m = '{32'h0000b505, 32'hffff4afb, 0, 32'h0000b505, 32'h0000b505, 0}; add_matrix(m);
      m = '{32'h00010000, 32'h00020000, 1, 32'h00020000, 32'h00040000, 2}; add_matrix(m);
      m = '{32'h7fffffff, 0, 32'h7fffffff, 0, 32'h7fffffff, 32'h80000000}; add_matrix(m);
      m = '{32'h00000100, 0, 32'h55555555, 0, 32'hffffff00, 32'haaaaaaaa}; add_matrix(m);
      for (int i = 0; i < N_RANDOM; i++) begin
         if (i == N_RANDOM / 2) begin
            // let the pipeline empty completely before going on
            wait (pending_q.size() == 0);
            drain_hold = 1'b1;
            wait (!req_valid);
            wait (inverse_q.size() == 0);
            drain_hold = 1'b0;
         end
         add_matrix(make_matrix($urandom_range(0, 7)));
      end
      stim_done = 1'b1;
   end

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid  <= 1'b0;
         burst_left <= 0;
         gap_left   <= 0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) begin
            add_prediction('{req_coef_a, req_coef_b, req_coef_c,
                             req_coef_d, req_coef_e, req_coef_f});
         end
         if (gap_left > 0 || drain_hold || pending_q.size() == 0) begin
            req_valid <= 1'b0;
            if (gap_left > 0) gap_left <= gap_left - 1;
         end else begin
            matrix_type m;
            m = pending_q.pop_front();
            req_valid  <= 1'b1;
            req_coef_a <= m.a; req_coef_b <= m.b; req_coef_c <= m.c;
            req_coef_d <= m.d; req_coef_e <= m.e; req_coef_f <= m.f;
            if (burst_left > 0) begin
               burst_left <= burst_left - 1;
            end else begin
               burst_left <= $urandom_range(0, 40);
               gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
         end
      end
   end

   // receiver stall pattern, with one long hold-off to fill the pipeline
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall   <= 1'b0;
         hold_cycles <= 0;
      end else if (cycle_count == 300) begin
         rsp_stall   <= 1'b1;
         hold_cycles <= 150;
      end else if (hold_cycles > 0) begin
         rsp_stall   <= 1'b1;
         hold_cycles <= hold_cycles - 1;
      end else if ((cycle_count / 200) % 3 == 1) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 3) == 0);
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (inverse_q.size() == 0) begin
            $display("unexpected result beat at cycle %0d", cycle_count);
            error_count++;
         end else begin
            inverse_type want;
            want = inverse_q.pop_front();
            if (rsp_inv_a !== want.a) report_mismatch("inv_a", rsp_inv_a, want.a);
            if (rsp_inv_b !== want.b) report_mismatch("inv_b", rsp_inv_b, want.b);
            if (rsp_inv_c !== want.c) report_mismatch("inv_c", rsp_inv_c, want.c);
            if (rsp_inv_d !== want.d) report_mismatch("inv_d", rsp_inv_d, want.d);
            if (rsp_inv_e !== want.e) report_mismatch("inv_e", rsp_inv_e, want.e);
            if (rsp_inv_f !== want.f) report_mismatch("inv_f", rsp_inv_f, want.f);
            if (rsp_invertible !== want.invertible)
               report_mismatch("invertible", CW'(rsp_invertible), CW'(want.invertible));
            if (rsp_saturated !== want.saturated)
               report_mismatch("saturated", CW'(rsp_saturated), CW'(want.saturated));
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         cycle_count <= 0;
      end else begin
         cycle_count <= cycle_count + 1;
         if (cycle_count >= MAX_CYCLE) begin
            $display("timeout");
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   initial begin
      reset      = 1'b1;
      req_valid  = 1'b0;
      rsp_stall  = 1'b0;
      req_coef_a = '0; req_coef_b = '0; req_coef_c = '0;
      req_coef_d = '0; req_coef_e = '0; req_coef_f = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      wait (stim_done && pending_q.size() == 0);
      @(posedge clock);
      while (req_valid || inverse_q.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
